### hw/rtl/tpgtg_pkg.sv
package tpgtg_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = $clog2(NSTEPS);

    // angle / error word, covers bearing minus heading before wrap
    localparam int ANG_W  = 22;
    // cordic x/y word: 25-bit difference, 8-bit prescale, gain growth
    localparam int CRD_W  = 36;
    localparam int DIFF_W = 25;
    localparam int SQ_W   = 50;
    localparam int ROOT_W = 25;
    localparam int MUL_W  = 26;

    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint PI_QL  = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam logic signed [ANG_W-1:0] PI_Q     = ANG_W'(PI_QL);
    localparam logic signed [ANG_W-1:0] TWO_PI_Q = ANG_W'(2 * PI_QL);

    typedef logic [1:0] t_op;
    localparam t_op OP_POSE   = 2'd0;
    localparam t_op OP_GOAL   = 2'd1;
    localparam t_op OP_CANCEL = 2'd2;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_ROTATE = 2'd0;
    localparam t_phase PH_DRIVE  = 2'd1;
    localparam t_phase PH_ALIGN  = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_IDLE      = 3'd0;
    localparam t_status ST_RUNNING   = 3'd1;
    localparam t_status ST_SUCCEEDED = 3'd2;
    localparam t_status ST_CANCELED  = 3'd3;
    localparam t_status ST_ACCEPTED  = 3'd4;
    localparam t_status ST_PREEMPTED = 3'd5;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DIST_GAIN = 2'd0;
    localparam t_cfg_idx CFG_ANG_GAIN  = 2'd1;
    localparam t_cfg_idx CFG_THRESHOLD = 2'd2;

    typedef longint t_atan_tab [ATAN_ENTRIES];
    localparam t_atan_tab ATAN_Q30 = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543515,
        16775851, 8388438, 4194282, 2097150, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
    };

    // arctan(2^-i), rounded from Q30
    function automatic logic signed [ANG_W-1:0] atan_q(input logic [STEP_W-1:0] idx);
        longint v;
        v = (ATAN_Q30[idx] + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        return ANG_W'(v);
    endfunction

    function automatic logic [23:0] sat24(input logic signed [2*MUL_W-9:0] v);
        logic [23:0] res;
        if (v > 44'sd8388607) begin
            res = 24'h7FFFFF;
        end else if (v < -44'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/three_phase_go_to_goal_controller.sv
// Go-to-goal proportional controller for a differential-drive base. Each transfer
// in gives exactly one transfer out. A goal item (op 1) stores the target and arms
// the controller, a cancel (op 2 or 3) drops it, and a pose sample (op 0) returns
// a velocity command: phase 0 turns toward the goal bearing, phase 1 drives and
// steers, phase 2 turns to the final heading. Goal, cancel and idle pose items go
// straight to the result. A pose sample with an armed goal runs two squares on the
// shared multiplier, a 25-step bit-serial square root, a 16-step vectoring CORDIC
// for the bearing when it is needed (phases 0 and 1, not phase 2 or the tick that
// ends phase 1), wrap steps and up to two gain products, all back to back. The
// input is not ready while an item is in work; a finished result sits in the
// output register so the next item can be taken while it waits.
module three_phase_go_to_goal_controller (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration writes
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_wdata,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // x_value[23:0], y_value[47:24], theta_value[66:48]
    input  logic [1:0]   s_axis_tuser,  // op[1:0]
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // linear_speed, angular_speed, report_x,
                                        // report_y, distance_left[118:96]
    output logic [4:0]   m_axis_tuser   // phase_now[1:0], status[4:2]
);
    import tpgtg_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_SQX  = 10'b0000000010,
        S_SQY  = 10'b0000000100,
        S_ROOT = 10'b0000001000,
        S_CORD = 10'b0000010000,
        S_WRAP = 10'b0000100000,
        S_DEC  = 10'b0001000000,
        S_MULL = 10'b0010000000,
        S_MULA = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_dist_gain, r_ang_gain, r_thr;

    // goal state
    logic signed [23:0] r_tgt_x, r_tgt_y;
    logic signed [18:0] r_tgt_th;
    logic               r_active;
    t_phase             r_phase;

    // per-item work registers
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [18:0]       r_tv;
    logic [SQ_W-1:0]          r_acc;
    logic [ROOT_W-1:0]        r_dist;
    logic signed [ANG_W-1:0]  r_e;
    logic [23:0]              r_lin, r_ang, r_rx, r_ry;
    t_phase                   r_ph_out;
    t_status                  r_status;

    // output register
    logic         r_mvalid;
    logic [119:0] r_mdata;
    logic [4:0]   r_muser;

    // input fields
    t_op                in_op;
    logic signed [23:0] in_x, in_y;
    logic signed [18:0] in_th;
    logic               s_acc;

    assign in_op = s_axis_tuser;
    assign in_x  = s_axis_tdata[23:0];
    assign in_y  = s_axis_tdata[47:24];
    assign in_th = s_axis_tdata[66:48];
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // shared multiplier
    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic signed [2*MUL_W-1:0]   prod;
    logic signed [2*MUL_W-9:0]   prod_sh;

    always_comb begin
        unique case (r_state)
            S_SQX: begin
                mul_a = MUL_W'(r_dx);
                mul_b = MUL_W'(r_dx);
            end
            S_SQY: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(r_dy);
            end
            S_MULL: begin
                mul_a = signed'({10'b0, r_dist_gain});
                mul_b = signed'({1'b0, r_dist});
            end
            default: begin
                mul_a = signed'({10'b0, r_ang_gain});
                mul_b = MUL_W'(r_e);
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_sh = prod[2*MUL_W-1:8];  // gain is Q8.8, floor shift

    // root and bearing units
    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic              cord_start, cord_done;
    logic signed [ANG_W-1:0] cord_angle;
    logic              need_cord, dist_gt, e_gt;
    logic [ANG_W-1:0]  e_mag;

    assign sq_start   = (r_state == S_SQY);
    assign dist_gt    = (sq_root > ROOT_W'(r_thr));
    assign need_cord  = (r_phase == PH_ROTATE) || ((r_phase == PH_DRIVE) && dist_gt);
    assign cord_start = (r_state == S_ROOT) && sq_done && need_cord;
    assign e_mag      = r_e[ANG_W-1] ? ANG_W'(-r_e) : ANG_W'(r_e);
    assign e_gt       = (e_mag > ANG_W'(r_thr));

    tpgtg_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_acc + prod[SQ_W-1:0]),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    tpgtg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_done  (cord_done),
        .o_angle (cord_angle)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (in_op == OP_POSE && r_active) ? S_SQX : S_DONE;
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_ROOT;
            S_ROOT: begin
                if (sq_done) begin
                    if (r_phase != PH_ROTATE && r_phase != PH_DRIVE) begin
                        n_state = S_WRAP;
                    end else if (need_cord) begin
                        n_state = S_CORD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CORD: begin
                if (cord_done) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (r_e <= PI_Q && r_e >= -PI_Q) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_phase == PH_DRIVE) begin
                    n_state = S_MULL;
                end else begin
                    n_state = e_gt ? S_MULA : S_DONE;
                end
            end
            S_MULL: n_state = S_MULA;
            S_MULA: n_state = S_DONE;
            S_DONE: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_gain <= 16'd1280;
            r_ang_gain  <= 16'd2560;
            r_thr       <= 16'd655;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DIST_GAIN: r_dist_gain <= i_cfg_wdata;
                CFG_ANG_GAIN:  r_ang_gain  <= i_cfg_wdata;
                CFG_THRESHOLD: r_thr       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // goal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= PH_ROTATE;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_tgt_th <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (in_op == OP_GOAL) begin
                            r_tgt_x  <= in_x;
                            r_tgt_y  <= in_y;
                            r_tgt_th <= in_th;
                            r_active <= 1'b1;
                            r_phase  <= PH_ROTATE;
                        end else if (in_op != OP_POSE) begin
                            r_active <= 1'b0;
                            r_phase  <= PH_ROTATE;
                        end
                    end
                end
                S_ROOT: begin
                    if (sq_done && r_phase == PH_DRIVE && !dist_gt) begin
                        r_phase <= PH_ALIGN;
                    end
                end
                S_DEC: begin
                    if (!e_gt) begin
                        if (r_phase == PH_ROTATE) begin
                            r_phase <= PH_DRIVE;
                        end else if (r_phase != PH_DRIVE) begin
                            // final heading reached
                            r_active <= 1'b0;
                            r_phase  <= PH_ROTATE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_lin    <= '0;
                    r_ang    <= '0;
                    r_dist   <= '0;
                    r_ph_out <= PH_ROTATE;
                    r_rx     <= '0;
                    r_ry     <= '0;
                    r_dx     <= DIFF_W'(r_tgt_x) - DIFF_W'(in_x);
                    r_dy     <= DIFF_W'(r_tgt_y) - DIFF_W'(in_y);
                    r_tv     <= in_th;
                    if (in_op == OP_GOAL) begin
                        r_status <= r_active ? ST_PREEMPTED : ST_ACCEPTED;
                    end else if (in_op == OP_POSE) begin
                        r_rx     <= in_x;
                        r_ry     <= in_y;
                        r_status <= r_active ? ST_RUNNING : ST_IDLE;
                    end else begin
                        r_status <= r_active ? ST_CANCELED : ST_IDLE;
                    end
                end
            end
            S_SQX: r_acc <= prod[SQ_W-1:0];
            S_ROOT: begin
                if (sq_done) begin
                    r_dist   <= sq_root;
                    r_ph_out <= r_phase;
                    r_e      <= ANG_W'(r_tgt_th) - ANG_W'(r_tv);
                end
            end
            S_CORD: begin
                if (cord_done) begin
                    r_e <= cord_angle - ANG_W'(r_tv);
                end
            end
            S_WRAP: begin
                if (r_e > PI_Q) begin
                    r_e <= r_e - TWO_PI_Q;
                end else if (r_e < -PI_Q) begin
                    r_e <= r_e + TWO_PI_Q;
                end
            end
            S_DEC: begin
                if (!e_gt && r_phase != PH_ROTATE && r_phase != PH_DRIVE) begin
                    r_status <= ST_SUCCEEDED;
                end
            end
            S_MULL: r_lin <= sat24(prod_sh);
            S_MULA: r_ang <= sat24(prod_sh);
            default: ;
        endcase
    end

    // output register
    logic [22:0] dist_sat;
    assign dist_sat = (r_dist[ROOT_W-1:23] != '0) ? 23'h7FFFFF : r_dist[22:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_mvalid || m_axis_tready)) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_mvalid || m_axis_tready)) begin
            r_mdata <= {1'b0, dist_sat, r_ry, r_rx, r_ang, r_lin};
            r_muser <= {r_status, r_ph_out};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

    // no phase progress without an armed goal
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_phase == PH_ROTATE))
        else $error("phase advanced with no active goal");

    // busy right after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input ready in the cycle after a transfer");

    // success result only after the goal was dropped
    a_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_SUCCEEDED) |-> !r_active)
        else $error("goal still armed on success");

    // bearing result only lands while waiting for it
    a_cord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> (r_state == S_CORD))
        else $error("cordic finished outside bearing state");

endmodule

### hw/rtl/tpgtg_sqrt.sv
module tpgtg_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tpgtg_pkg::SQ_W-1:0]    i_radicand,
    output logic                          o_done,
    output logic [tpgtg_pkg::ROOT_W-1:0]  o_root
);
    import tpgtg_pkg::*;

    localparam int K_W = $clog2(ROOT_W);

    logic [SQ_W-1:0] r_n, r_r;
    logic [K_W-1:0]  r_k;
    logic            r_busy, r_done;
    logic [SQ_W-1:0] bit_v, trial;
    logic            take;

    // one root bit per cycle, bit = 4^k
    assign bit_v = SQ_W'(1) << {r_k, 1'b0};
    assign trial = r_r + bit_v;
    assign take  = (r_n >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_k == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_k == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_radicand;
            r_r <= '0;
            r_k <= K_W'(ROOT_W - 1);
        end else if (r_busy) begin
            if (take) begin
                r_n <= r_n - trial;
                r_r <= (r_r >> 1) + bit_v;
            end else begin
                r_r <= r_r >> 1;
            end
            r_k <= r_k - K_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

### hw/rtl/tpgtg_cordic.sv
module tpgtg_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [tpgtg_pkg::DIFF_W-1:0]  i_dx,
    input  logic signed [tpgtg_pkg::DIFF_W-1:0]  i_dy,
    output logic                                 o_done,
    output logic signed [tpgtg_pkg::ANG_W-1:0]   o_angle
);
    import tpgtg_pkg::*;

    logic signed [CRD_W-1:0] r_x, r_y, x0, y0, sx, sy;
    logic signed [ANG_W-1:0] r_z, t;
    logic [STEP_W-1:0]       r_i;
    logic                    r_busy, r_done, r_zero, last;

    // prescale by 256 to keep fraction bits through the shifts
    assign x0   = CRD_W'(i_dx) <<< 8;
    assign y0   = CRD_W'(i_dy) <<< 8;
    assign sx   = r_x >>> r_i;
    assign sy   = r_y >>> r_i;
    assign t    = atan_q(r_i);
    assign last = (r_i == STEP_W'(NSTEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_zero <= (i_dx == '0) && (i_dy == '0);
            if (x0 < 0) begin
                // left half plane: fold over, preload +/- pi
                r_z <= (y0 >= 0) ? PI_Q : -PI_Q;
                r_x <= -x0;
                r_y <= -y0;
            end else begin
                r_z <= '0;
                r_x <= x0;
                r_y <= y0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + t;
            end else begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - t;
            end
            r_i <= r_i + STEP_W'(1);
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : r_z;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tpgtg_pkg::*;

    // ---------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ---------------------------------------------------------------------
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;   // x_value[23:0], y_value[47:24], theta_value[66:48]
    logic [1:0]   s_axis_tuser = '0;   // op[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;        // lin, ang, rep_x, rep_y, dist_left[118:96]
    logic [4:0]   m_axis_tuser;        // phase_now[1:0], status[4:2]

    always #5 i_clk = ~i_clk;

    three_phase_go_to_goal_controller dut (.*);

    // ---------------------------------------------------------------------
    // Transfer types
    // ---------------------------------------------------------------------
    typedef struct {
        logic [1:0]         op;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [18:0] th;
    } pose_cmd_t;

    typedef struct packed {
        logic [23:0] lin;
        logic [23:0] ang;
        logic [23:0] rx;
        logic [23:0] ry;
        logic [22:0] dleft;
        logic [1:0]  ph;
        logic [2:0]  st;
    } drive_cmd_t;

    pose_cmd_t  cmd_q[$];       // items waiting for the driver
    drive_cmd_t drive_exp_q[$]; // predicted velocity commands, oldest first

    // ---------------------------------------------------------------------
    // Controller shadow state
    // ---------------------------------------------------------------------
    longint     kd_gain, ka_gain, thresh;
    longint     goal_x, goal_y, goal_th;
    bit         armed;
    logic [1:0] cur_phase;

    longint PI_L, TWO_PI_L;

    int errors = 0;
    int n_sent = 0, n_got = 0;
    int idle_cycles = 0;
    bit hold_tx = 0;
    int n_goal = 0, n_succ = 0, n_cancel = 0;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // wrap into [-pi, pi]
    function automatic longint wrap_pi(longint a);
        longint k;
        if (a > PI_L) begin
            k = (a - PI_L + TWO_PI_L - 1) / TWO_PI_L;
            a = a - k * TWO_PI_L;
        end else if (a < -PI_L) begin
            k = (-PI_L - a + TWO_PI_L - 1) / TWO_PI_L;
            a = a + k * TWO_PI_L;
        end
        return a;
    endfunction

    // vectoring CORDIC atan2 with 8-bit prescale
    function automatic longint goal_bearing(longint dy, longint dx);
        longint cx, cy, z, nx, ny, t;
        int n;
        cx = dx * 256;
        cy = dy * 256;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (cx < 0) begin
            z = (cy >= 0) ? PI_L : -PI_L;
            cx = -cx;
            cy = -cy;
        end
        n = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
        for (int i = 0; i < n; i++) begin
            t = (ATAN_Q30[i] + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            if (cy >= 0) begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                z = z + t;
            end else begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                z = z - t;
            end
            cx = nx;
            cy = ny;
        end
        return z;
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic longint absv(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the shadow controller by one item, return the expected command.
    function automatic drive_cmd_t predict_drive(pose_cmd_t c);
        drive_cmd_t r;
        longint dx, dy, d, e, lin, ang;
        lin = 0;
        ang = 0;
        d = 0;
        r.rx = '0;
        r.ry = '0;
        r.ph = PH_ROTATE;
        r.st = ST_IDLE;
        if (c.op == OP_GOAL) begin
            r.st = armed ? ST_PREEMPTED : ST_ACCEPTED;
            goal_x = c.x;
            goal_y = c.y;
            goal_th = c.th;
            armed = 1;
            cur_phase = PH_ROTATE;
        end else if (c.op == OP_POSE) begin
            r.rx = c.x;
            r.ry = c.y;
            if (armed) begin
                dx = goal_x - longint'(c.x);
                dy = goal_y - longint'(c.y);
                d = root_floor(dx * dx + dy * dy);
                r.ph = cur_phase;
                r.st = ST_RUNNING;
                if (cur_phase == PH_ROTATE) begin
                    e = wrap_pi(goal_bearing(dy, dx) - longint'(c.th));
                    if (absv(e) > thresh) ang = shr_floor(ka_gain * e, 8);
                    else cur_phase = PH_DRIVE;
                end else if (cur_phase == PH_DRIVE) begin
                    if (d > thresh) begin
                        e = wrap_pi(goal_bearing(dy, dx) - longint'(c.th));
                        lin = shr_floor(kd_gain * d, 8);
                        ang = shr_floor(ka_gain * e, 8);
                    end else begin
                        cur_phase = PH_ALIGN;
                    end
                end else begin
                    e = wrap_pi(goal_th - longint'(c.th));
                    if (absv(e) > thresh) begin
                        ang = shr_floor(ka_gain * e, 8);
                    end else begin
                        r.st = ST_SUCCEEDED;
                        armed = 0;
                        cur_phase = PH_ROTATE;
                    end
                end
            end
        end else begin
            // cancel; opcode three behaves the same
            if (armed) begin
                r.st = ST_CANCELED;
                armed = 0;
                cur_phase = PH_ROTATE;
            end
        end
        r.lin = clamp24(lin);
        r.ang = clamp24(ang);
        r.dleft = (d > 8388607) ? 23'h7FFFFF : d[22:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: pops pending items, random gaps, predicts on acceptance
    // ---------------------------------------------------------------------
    int tx_gap = 0;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pose_cmd_t c;
                c.op = s_axis_tuser;
                c.x = s_axis_tdata[23:0];
                c.y = s_axis_tdata[47:24];
                c.th = s_axis_tdata[66:48];
                drive_exp_q.push_back(predict_drive(c));
                n_sent++;
                tx_gap = pick_gap();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap == 0 && !hold_tx && cmd_q.size() > 0) begin
                    pose_cmd_t c;
                    c = cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= c.op;
                    s_axis_tdata <= {5'b0, c.th, c.y, c.x};
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (tx_gap > 0) tx_gap--;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random back-pressure, compare against oldest prediction
    // ---------------------------------------------------------------------
    int rx_gap = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                drive_cmd_t a, x;
                a.lin = m_axis_tdata[23:0];
                a.ang = m_axis_tdata[47:24];
                a.rx = m_axis_tdata[71:48];
                a.ry = m_axis_tdata[95:72];
                a.dleft = m_axis_tdata[118:96];
                a.ph = m_axis_tuser[1:0];
                a.st = m_axis_tuser[4:2];
                n_got++;
                if (drive_exp_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected command lin=%h ang=%h st=%0d",
                             $time, a.lin, a.ang, a.st);
                end else begin
                    x = drive_exp_q.pop_front();
                    if (a.st == ST_ACCEPTED || a.st == ST_PREEMPTED) n_goal++;
                    if (a.st == ST_SUCCEEDED) n_succ++;
                    if (a.st == ST_CANCELED) n_cancel++;
                    if (a != x) begin
                        errors++;
                        $display({"%0t: mismatch exp lin=%h ang=%h rx=%h ry=%h ",
                                  "dist=%h ph=%0d st=%0d"},
                                 $time, x.lin, x.ang, x.rx, x.ry, x.dleft, x.ph, x.st);
                        $display({"%0t:          got lin=%h ang=%h rx=%h ry=%h ",
                                  "dist=%h ph=%0d st=%0d"},
                                 $time, a.lin, a.ang, a.rx, a.ry, a.dleft, a.ph, a.st);
                    end
                end
                rx_gap = pick_gap();
            end
            if (rx_gap > 0) begin
                m_axis_tready <= 1'b0;
                rx_gap--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: cycles without any transfer
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic void add_item(logic [1:0] op, longint x, longint y, longint th);
        pose_cmd_t c;
        c.op = op;
        c.x = x[23:0];
        c.y = y[23:0];
        c.th = th[18:0];
        cmd_q.push_back(c);
    endfunction

    function automatic longint rnd_angle();
        return longint'($urandom_range(0, 411774)) - 205887;
    endfunction

    function automatic longint rnd_pos();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6) return longint'($urandom_range(0, 2000000)) - 1000000;
        if (p < 8) return longint'($urandom_range(0, 16777215)) - 8388608;
        return longint'($urandom_range(0, 2000)) - 1000;
    endfunction

    // goal followed by a converging pose walk that steps through the phases
    task automatic queue_mission();
        longint gx, gy, gt, px, py, pt, b;
        int steps;
        gx = rnd_pos();
        gy = rnd_pos();
        gt = rnd_angle();
        add_item(OP_GOAL, gx, gy, gt);
        px = rnd_pos();
        py = rnd_pos();
        pt = rnd_angle();
        steps = $urandom_range(3, 12);
        for (int i = 0; i < steps; i++) begin
            add_item(OP_POSE, px, py, pt);
            b = wrap_pi(goal_bearing(gy - py, gx - px));
            if (b > 205887) b = 205887;
            if (b < -205887) b = -205887;
            pt = (i % 2) ? b : pt + (b - pt) / 2;
            px = px + (gx - px) / 2;
            py = py + (gy - py) / 2;
        end
        // arrive, then align to the goal heading
        add_item(OP_POSE, gx, gy, pt);
        add_item(OP_POSE, gx, gy, gt + $urandom_range(0, 2000) - 1000);
        add_item(OP_POSE, gx, gy, gt);
        add_item(OP_POSE, gx, gy, gt);
        if ($urandom_range(0, 5) == 0) add_item(2'($urandom_range(2, 3)), 0, 0, 0);
    endtask

    task automatic wait_drained();
        while (cmd_q.size() > 0 || s_axis_tvalid || drive_exp_q.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DIST_GAIN: kd_gain = v;
            CFG_ANG_GAIN:  ka_gain = v;
            CFG_THRESHOLD: thresh = v;
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        PI_L = PI_QL;
        TWO_PI_L = 2 * PI_QL;
        kd_gain = 1280;
        ka_gain = 2560;
        thresh = 655;
        goal_x = 0;
        goal_y = 0;
        goal_th = 0;
        armed = 0;
        cur_phase = PH_ROTATE;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle cases, extremes, goal at robot position, preempt, cancel
        add_item(OP_CANCEL, 0, 0, 0);
        add_item(OP_POSE, 8388607, -8388608, 205887);
        add_item(2'd3, -1, -1, -1);
        add_item(OP_GOAL, 8388607, 8388607, 205887);
        add_item(OP_POSE, -8388608, -8388608, -205887);
        add_item(OP_GOAL, -8388608, 8388607, -205887);
        add_item(OP_POSE, 8388607, -8388608, 0);
        add_item(OP_POSE, 8388607, -8388608, 205887);
        add_item(OP_CANCEL, 0, 0, 0);
        add_item(OP_GOAL, 1000, 2000, 50000);
        add_item(OP_POSE, 1000, 2000, 0);          // robot on the goal: bearing 0
        add_item(OP_POSE, 1000, 2000, 0);          // drive phase ends at once
        add_item(OP_POSE, 1000, 2000, 10000);      // align, still off
        add_item(OP_POSE, 1000, 2000, 50000);      // success
        add_item(OP_GOAL, -65536, 0, 0);
        add_item(OP_POSE, 0, 0, 205887);           // bearing pi, wrap
        add_item(OP_POSE, 0, 0, -205887);
        add_item(2'd3, 0, 0, 0);                   // opcode three cancels
        wait_drained();

        // configuration sweep, extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin cfg_write(CFG_DIST_GAIN, 16'hFFFF); cfg_write(CFG_ANG_GAIN, 16'hFFFF);
                         cfg_write(CFG_THRESHOLD, 16'h0000); end
                1: begin cfg_write(CFG_DIST_GAIN, 16'h0000); cfg_write(CFG_ANG_GAIN, 16'h0000);
                         cfg_write(CFG_THRESHOLD, 16'hFFFF); end
                2: begin cfg_write(CFG_DIST_GAIN, 16'd1280); cfg_write(CFG_ANG_GAIN, 16'd2560);
                         cfg_write(CFG_THRESHOLD, 16'd655); end
                default: begin
                    cfg_write(CFG_DIST_GAIN, 16'($urandom_range(0, 65535)));
                    cfg_write(CFG_ANG_GAIN, 16'($urandom_range(0, 65535)));
                    cfg_write(CFG_THRESHOLD, 16'($urandom_range(0, 20000)));
                end
            endcase
            while (cmd_q.size() < 215) begin
                if ($urandom_range(0, 9) < 8) begin
                    queue_mission();
                end else begin
                    add_item(2'($urandom_range(0, 3)), rnd_pos(), rnd_pos(), rnd_angle());
                end
            end
            // hold the sender once until all commands are back
            if (ph == 3) begin
                while (cmd_q.size() > 100) @(posedge i_clk);
                hold_tx = 1;
                while (drive_exp_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                hold_tx = 0;
            end
            wait_drained();
        end

        $display("sent %0d items, checked %0d commands over 6 gain/threshold settings",
                 n_sent, n_got);
        $display("goals %0d, succeeded %0d, canceled %0d", n_goal, n_succ, n_cancel);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
